// ----- rtl/core/hpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the homogeneous point transform.
// No dependencies; every other file imports this package.

package hpt_pkg;

    localparam int COEF_W    = 32;
    localparam int IDX_W     = 4;
    localparam int NUM_COLS  = 4;
    localparam int NUM_LANES = 3;
    localparam int MAT_N     = NUM_COLS * NUM_COLS;
    localparam int W_COL     = NUM_COLS - 1;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int PART_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = SUM_W - 1;
    localparam int REM_W     = MAG_W + 1;
    localparam int QBITS     = COEF_W;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_XFORM = 1'b1;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PART_W-1:0] part_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [REM_W-1:0]         rem_t;
    typedef logic [QBITS-1:0]         quo_t;

    localparam coef_t OUT_MAX = 32'sh7FFF_FFFF;
    localparam coef_t OUT_MIN = 32'sh8000_0000;

    typedef struct packed {
        mag_t mag;
        logic neg;
    } hpt_smag_t;

endpackage

`default_nettype wire

// ----- rtl/core/hpt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Request and result channel interfaces of the point transform.
// Depends on hpt_pkg.

interface hpt_req_if import hpt_pkg::*;;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [IDX_W-1:0] entry_index;
    coef_t            coeff_value;
    coef_t            point_x;
    coef_t            point_y;
    coef_t            point_z;

    modport source (output valid, req_type, entry_index, coeff_value,
                    point_x, point_y, point_z, input ready);
    modport sink   (input valid, req_type, entry_index, coeff_value,
                    point_x, point_y, point_z, output ready);
endinterface

interface hpt_res_if import hpt_pkg::*;;
    logic  valid;
    logic  ready;
    coef_t out_x;
    coef_t out_y;
    coef_t out_z;
    logic  w_zero_flag;

    modport source (output valid, out_x, out_y, out_z, w_zero_flag, input ready);
    modport sink   (input valid, out_x, out_y, out_z, w_zero_flag, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hpt_matrix.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Matrix store and first pipeline stage: twelve products and the w-row bias.
// Depends on hpt_pkg.

module hpt_matrix import hpt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             load_we,
    input  wire logic [IDX_W-1:0] load_index,
    input  wire coef_t            load_value,
    input  wire logic             xf_valid,
    input  wire coef_t            pt [NUM_LANES],
    output logic                  valid_o,
    output prod_t                 prod_o [NUM_COLS][NUM_LANES],
    output prod_t                 bias_o [NUM_COLS]
);

    localparam coef_t ONE = coef_t'(1) <<< FRAC_BITS;

    coef_t matrix_reg [MAT_N];
    logic  valid_reg;
    prod_t prod_reg  [NUM_COLS][NUM_LANES];
    prod_t prod_next [NUM_COLS][NUM_LANES];
    prod_t bias_reg  [NUM_COLS];
    prod_t bias_next [NUM_COLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAT_N; k++)
            begin
                matrix_reg[k] <= ((k % NUM_COLS) == (k / NUM_COLS)) ? ONE : '0;
            end
        end
        else if (load_we)
        begin
            matrix_reg[load_index] <= load_value;
        end
    end

    // out_i = sum_j M[j][i] * p_j; the w row enters as a shifted bias
    always_comb
    begin
        for (int i = 0; i < NUM_COLS; i++)
        begin
            for (int j = 0; j < NUM_LANES; j++)
            begin
                prod_next[i][j] = prod_t'(pt[j]) * prod_t'(matrix_reg[j * NUM_COLS + i]);
            end
            bias_next[i] = prod_t'(matrix_reg[W_COL * NUM_COLS + i]) <<< FRAC_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= xf_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            bias_reg <= bias_next;
        end
    end

    assign valid_o = valid_reg;
    assign prod_o  = prod_reg;
    assign bias_o  = bias_reg;

endmodule

`default_nettype wire

// ----- rtl/core/hpt_accum.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Column sums in two adder stages, then sign and magnitude split.
// Depends on hpt_pkg.

module hpt_accum import hpt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  valid_i,
    input  wire prod_t prod_i [NUM_COLS][NUM_LANES],
    input  wire prod_t bias_i [NUM_COLS],
    output logic       valid_o,
    output hpt_smag_t  h_o [NUM_COLS]
);

    logic      va_reg;
    logic      vb_reg;
    logic      vc_reg;
    part_t     pa_reg [NUM_COLS];
    part_t     pb_reg [NUM_COLS];
    sum_t      sum_reg [NUM_COLS];
    hpt_smag_t h_reg [NUM_COLS];
    part_t     pa_next [NUM_COLS];
    part_t     pb_next [NUM_COLS];
    sum_t      sum_next [NUM_COLS];
    hpt_smag_t h_next [NUM_COLS];

    always_comb
    begin
        for (int i = 0; i < NUM_COLS; i++)
        begin
            pa_next[i]  = part_t'(prod_i[i][0]) + part_t'(prod_i[i][1]);
            pb_next[i]  = part_t'(prod_i[i][2]) + part_t'(bias_i[i]);
            sum_next[i] = sum_t'(pa_reg[i]) + sum_t'(pb_reg[i]);
            h_next[i].neg = sum_reg[i][SUM_W-1];
            h_next[i].mag = sum_reg[i][SUM_W-1] ? mag_t'(-sum_reg[i]) : mag_t'(sum_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= valid_i;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            sum_reg <= sum_next;
            h_reg   <= h_next;
        end
    end

    assign valid_o = vc_reg;
    assign h_o     = h_reg;

endmodule

`default_nettype wire

// ----- rtl/core/hpt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage for x, y and z,
// followed by the saturating output stage. Depends on hpt_pkg.

module hpt_div import hpt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      valid_i,
    input  wire hpt_smag_t h_i [NUM_COLS],
    output logic           valid_o,
    output coef_t          res_o [NUM_LANES],
    output logic           w_zero_o
);

    localparam int NST   = QBITS + 1;
    localparam int LAST  = NST - 1;
    localparam int NSH_W = MAG_W + FRAC_BITS;

    logic  v_reg    [NST];
    rem_t  rem_reg  [NST][NUM_LANES];
    rem_t  rem_next [NST][NUM_LANES];
    quo_t  q_reg    [NST][NUM_LANES];
    quo_t  q_next   [NST][NUM_LANES];
    mag_t  num_reg  [NST][NUM_LANES];
    mag_t  num_next [NST][NUM_LANES];
    logic  nneg_reg [NST][NUM_LANES];
    logic  nneg_next[NST][NUM_LANES];
    logic  sat_reg  [NST][NUM_LANES];
    logic  sat_next [NST][NUM_LANES];
    mag_t  den_reg  [NST];
    mag_t  den_next [NST];
    logic  dneg_reg [NST];
    logic  dneg_next[NST];
    logic  wz_reg   [NST];
    logic  wz_next  [NST];
    logic  out_valid_reg;
    coef_t res_reg  [NUM_LANES];
    coef_t res_next [NUM_LANES];
    logic  wz_out_reg;

    always_comb
    begin
        logic [NSH_W-1:0] nsh;
        rem_t             rsh;
        logic             rneg;
        quo_t             q;

        // Entry: quotient at or above 2^32 saturates
        den_next[0]  = h_i[W_COL].mag;
        dneg_next[0] = h_i[W_COL].neg;
        wz_next[0]   = (h_i[W_COL].mag == '0);
        for (int l = 0; l < NUM_LANES; l++)
        begin
            num_next[0][l]  = h_i[l].mag;
            nneg_next[0][l] = h_i[l].neg;
            rem_next[0][l]  = rem_t'(h_i[l].mag >> (QBITS - FRAC_BITS));
            sat_next[0][l]  = (rem_t'(h_i[l].mag >> (QBITS - FRAC_BITS))
                               >= rem_t'(h_i[W_COL].mag));
            q_next[0][l]    = '0;
        end

        // Bring down one dividend bit per stage
        for (int s = 1; s < NST; s++)
        begin
            den_next[s]  = den_reg[s-1];
            dneg_next[s] = dneg_reg[s-1];
            wz_next[s]   = wz_reg[s-1];
            for (int l = 0; l < NUM_LANES; l++)
            begin
                nsh = {num_reg[s-1][l], {FRAC_BITS{1'b0}}};
                rsh = {rem_reg[s-1][l][REM_W-2:0], nsh[QBITS - s]};
                num_next[s][l]  = num_reg[s-1][l];
                nneg_next[s][l] = nneg_reg[s-1][l];
                sat_next[s][l]  = sat_reg[s-1][l];
                if (rsh >= rem_t'(den_reg[s-1]))
                begin
                    rem_next[s][l] = rsh - rem_t'(den_reg[s-1]);
                    q_next[s][l]   = {q_reg[s-1][l][QBITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][l] = rsh;
                    q_next[s][l]   = {q_reg[s-1][l][QBITS-2:0], 1'b0};
                end
            end
        end

        // Sign and saturation
        for (int l = 0; l < NUM_LANES; l++)
        begin
            q    = q_reg[LAST][l];
            rneg = nneg_reg[LAST][l] ^ dneg_reg[LAST];
            if (wz_reg[LAST])
            begin
                res_next[l] = nneg_reg[LAST][l] ? OUT_MIN : OUT_MAX;
            end
            else if (sat_reg[LAST][l])
            begin
                res_next[l] = rneg ? OUT_MIN : OUT_MAX;
            end
            else if (rneg)
            begin
                res_next[l] = q[QBITS-1] ? OUT_MIN : -$signed(q);
            end
            else
            begin
                res_next[l] = q[QBITS-1] ? OUT_MAX : $signed(q);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= valid_i;
            for (int s = 1; s < NST; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            out_valid_reg <= v_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg    <= rem_next;
            q_reg      <= q_next;
            num_reg    <= num_next;
            nneg_reg   <= nneg_next;
            sat_reg    <= sat_next;
            den_reg    <= den_next;
            dneg_reg   <= dneg_next;
            wz_reg     <= wz_next;
            res_reg    <= res_next;
            wz_out_reg <= wz_reg[LAST];
        end
    end

    assign valid_o  = out_valid_reg;
    assign res_o    = res_reg;
    assign w_zero_o = wz_out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/homogeneous_point_transform.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the homogeneous point transform.
// Depends on hpt_pkg, hpt_if, hpt_matrix, hpt_accum and hpt_div.
//
// Transforms 3D points (signed fixed point, FRAC_BITS fraction bits) by a
// stored 4x4 matrix in row-vector form with w = 1, then divides x, y and z
// by the fourth component, truncating toward zero and saturating to 32 bits.
// A zero fourth component raises w_zero_flag and drives each output to the
// most positive or most negative value by the sign of its numerator. A load
// request writes one matrix entry (row*4 + column), produces no result, and
// takes effect for every transform request accepted after it; the matrix
// resets to identity. The block takes one request per cycle. A transform
// result passes through one multiply stage, three adder/magnitude stages,
// 33 stages of the one-bit-per-stage divider and the output register. The
// whole pipeline holds while a result waits on the result channel, so
// request ready follows result ready through one gate.

module homogeneous_point_transform import hpt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hpt_req_if.sink    req,
    hpt_res_if.source  res
);

    logic      en;
    logic      load_we;
    logic      xf_accept;
    coef_t     pt [NUM_LANES];
    logic      mat_valid;
    prod_t     prod [NUM_COLS][NUM_LANES];
    prod_t     bias [NUM_COLS];
    logic      acc_valid;
    hpt_smag_t hsum [NUM_COLS];
    logic      div_valid;
    coef_t     div_res [NUM_LANES];
    logic      div_wz;

    // Advance every stage unless a finished result is held
    assign en        = !div_valid || res.ready;
    assign req.ready = en;
    assign load_we   = req.valid && en && (req.req_type == REQ_LOAD);
    assign xf_accept = req.valid && en && (req.req_type == REQ_XFORM);

    assign pt[0] = req.point_x;
    assign pt[1] = req.point_y;
    assign pt[2] = req.point_z;

    hpt_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .load_we    (load_we),
        .load_index (req.entry_index),
        .load_value (req.coeff_value),
        .xf_valid   (xf_accept),
        .pt         (pt),
        .valid_o    (mat_valid),
        .prod_o     (prod),
        .bias_o     (bias)
    );

    hpt_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (mat_valid),
        .prod_i  (prod),
        .bias_i  (bias),
        .valid_o (acc_valid),
        .h_o     (hsum)
    );

    hpt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_i  (acc_valid),
        .h_i      (hsum),
        .valid_o  (div_valid),
        .res_o    (div_res),
        .w_zero_o (div_wz)
    );

    assign res.valid       = div_valid;
    assign res.out_x       = div_res[0];
    assign res.out_y       = div_res[1];
    assign res.out_z       = div_res[2];
    assign res.w_zero_flag = div_wz;

    // Only a transform request may start a result
    a_start_from_xform : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mat_valid) |-> $past(xf_accept))
        else $error("pipeline started without a transform request");

    // A load request never enters the pipeline
    a_load_no_result : assert property (@(posedge clk) disable iff (!rst_n)
        load_we |=> !mat_valid)
        else $error("load request entered the pipeline");

    // Zero w drives every coordinate to a saturation limit
    a_wzero_saturates : assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.w_zero_flag) |->
            ((res.out_x == OUT_MAX || res.out_x == OUT_MIN) &&
             (res.out_y == OUT_MAX || res.out_y == OUT_MIN) &&
             (res.out_z == OUT_MAX || res.out_z == OUT_MIN)))
        else $error("zero w result not saturated");

endmodule

`default_nettype wire

// ----- tb/sv/homogeneous_point_transform_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the homogeneous point transform: directed and
// random load and transform requests, each result checked against a predictor.
// Depends on hpt_pkg, hpt_if and the homogeneous_point_transform RTL.

module homogeneous_point_transform_tb;
    import hpt_pkg::*;

    localparam int FRAC       = 16;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 80;
    localparam int ENTRY_WW   = 3 * NUM_COLS + W_COL;   // bottom-right entry

    typedef struct {
        coef_t ox;
        coef_t oy;
        coef_t oz;
        logic  wz;
    } point_result_t;

    logic clk;
    logic rst_n;

    hpt_req_if req_ch ();
    hpt_res_if res_ch ();

    homogeneous_point_transform #(.FRAC_BITS(FRAC)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Predictor state: its own copy of the matrix store.
    coef_t         shadow_matrix [MAT_N];
    point_result_t pending_points [$];

    int  mismatches;
    int  loads_sent;
    int  points_sent;
    int  points_checked;
    int  zero_w_seen;
    int  burst_left;
    int  cycle_count;
    int  stall_mode;
    int  stall_left;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Reset the predicted matrix to identity.
    function automatic void reset_shadow_matrix();
        for (int k = 0; k < MAT_N; k++)
            shadow_matrix[k] = ((k % NUM_COLS) == (k / NUM_COLS)) ? coef_t'(1 << FRAC) : '0;
    endfunction

    // Exact row-vector product with w = 1.0, then truncating divide and saturate.
    function automatic point_result_t transform_point(coef_t px, coef_t py, coef_t pz);
        logic signed [69:0] pt [NUM_COLS];
        logic signed [69:0] hsum [NUM_COLS];
        logic signed [69:0] mval;
        logic [69:0]        num;
        logic [69:0]        den;
        logic [95:0]        quo;
        logic               neg;
        coef_t              lane [NUM_LANES];
        point_result_t      r;
        pt[0] = 70'(px);
        pt[1] = 70'(py);
        pt[2] = 70'(pz);
        pt[3] = 70'sd1 <<< FRAC;
        for (int i = 0; i < NUM_COLS; i++)
        begin
            hsum[i] = '0;
            for (int j = 0; j < NUM_COLS; j++)
            begin
                mval    = 70'(shadow_matrix[j * NUM_COLS + i]);
                hsum[i] = hsum[i] + mval * pt[j];
            end
        end
        r.wz = (hsum[W_COL] == 0);
        den  = hsum[W_COL][69] ? 70'(-hsum[W_COL]) : 70'(hsum[W_COL]);
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (r.wz)
            begin
                lane[i] = hsum[i][69] ? OUT_MIN : OUT_MAX;
            end
            else
            begin
                num = hsum[i][69] ? 70'(-hsum[i]) : 70'(hsum[i]);
                neg = hsum[i][69] ^ hsum[W_COL][69];
                quo = (96'(num) << FRAC) / 96'(den);
                if (num == 0)
                    lane[i] = '0;
                else if (neg)
                    lane[i] = (quo >= 96'h8000_0000) ? OUT_MIN : coef_t'(-quo[31:0]);
                else
                    lane[i] = (quo > 96'h7FFF_FFFF) ? OUT_MAX : coef_t'(quo[31:0]);
            end
        end
        r.ox = lane[0];
        r.oy = lane[1];
        r.oz = lane[2];
        return r;
    endfunction

    // Drive one request from a falling edge, hold it until accepted, update the
    // predictor, then leave valid up within a burst or drop it for a random gap.
    task automatic send_request(logic kind, logic [IDX_W-1:0] idx, coef_t coeff,
                                coef_t px, coef_t py, coef_t pz);
        int gap;
        req_ch.valid       = 1'b1;
        req_ch.req_type    = kind;
        req_ch.entry_index = idx;
        req_ch.coeff_value = coeff;
        req_ch.point_x     = px;
        req_ch.point_y     = py;
        req_ch.point_z     = pz;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (kind == REQ_LOAD)
        begin
            shadow_matrix[idx] = coeff;
            loads_sent++;
        end
        else
        begin
            pending_points.push_back(transform_point(px, py, pz));
            points_sent++;
        end
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic load_entry(int idx, coef_t coeff);
        send_request(REQ_LOAD, IDX_W'(idx), coeff, coef_t'($urandom), coef_t'($urandom),
                     coef_t'($urandom));
    endtask

    task automatic send_point(coef_t px, coef_t py, coef_t pz);
        send_request(REQ_XFORM, IDX_W'($urandom), coef_t'($urandom), px, py, pz);
    endtask

    task automatic restore_identity();
        for (int k = 0; k < MAT_N; k++)
            load_entry(k, ((k % NUM_COLS) == (k / NUM_COLS)) ? coef_t'(1 << FRAC) : '0);
    endtask

    // Pick a value that is often small, zero or exactly plus or minus one, sometimes fully random.
    function automatic coef_t pick_value();
        case ($urandom_range(0, 5))
            0: return coef_t'($urandom);
            1: return '0;
            2: return coef_t'(1 << FRAC);
            3: return -coef_t'(1 << FRAC);
            4: return coef_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return coef_t'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
        endcase
    endfunction

    // Identity matrix with the extreme coordinates passes points through.
    task automatic test_identity_extremes();
        send_point(OUT_MAX, OUT_MIN, '0);
        send_point(OUT_MIN, OUT_MAX, -coef_t'(1));
        send_point(coef_t'(1), -coef_t'(1 << FRAC), coef_t'(32'h5555_AAAA));
    endtask

    // Load ignores the point fields; transform ignores index and coefficient.
    task automatic test_load_fields_ignored();
        send_request(REQ_LOAD, IDX_W'(4), '0, OUT_MAX, OUT_MAX, OUT_MAX);
        send_request(REQ_XFORM, IDX_W'(15), OUT_MIN, coef_t'(3 << FRAC), coef_t'(7 << FRAC),
                     coef_t'(1 << FRAC));
        load_entry(4, '0);
    endtask

    // Perspective: w = z + 1, positive and negative divisors.
    task automatic test_perspective();
        load_entry(2 * NUM_COLS + W_COL, coef_t'(1 << FRAC));
        send_point(coef_t'(4 << FRAC), -coef_t'(6 << FRAC), coef_t'(1 << FRAC));
        send_point(coef_t'(5 << FRAC), coef_t'(1), -coef_t'(3 << FRAC));
        send_point(coef_t'(7), coef_t'(-7), coef_t'(2));
    endtask

    // Zero w raises the flag; outputs saturate by numerator sign, zero is positive.
    task automatic test_zero_w();
        send_point(-coef_t'(2 << FRAC), coef_t'(2 << FRAC), -coef_t'(1 << FRAC));
        load_entry(ENTRY_WW, '0);
        load_entry(2 * NUM_COLS + W_COL, '0);
        send_point(-coef_t'(5), '0, coef_t'(9));
    endtask

    // Huge numerator over a tiny w saturates without the flag.
    task automatic test_saturation();
        load_entry(ENTRY_WW, coef_t'(1));
        load_entry(0, OUT_MAX);
        send_point(OUT_MAX, OUT_MIN, coef_t'(1));
        send_point(OUT_MIN, coef_t'(1), -coef_t'(1));
        restore_identity();
    endtask

    // Random stream: mostly transforms, matrix loads in between, now and then
    // a reset back to identity so that results stay in range part of the time.
    task automatic test_random_stream(int count);
        coef_t px;
        coef_t py;
        coef_t pz;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                load_entry($urandom_range(0, MAT_N - 1), pick_value());
            end
            else if ($urandom_range(0, 199) == 0)
            begin
                restore_identity();
            end
            else
            begin
                px = pick_value();
                py = pick_value();
                pz = pick_value();
                send_point(px, py, pz);
            end
        end
    endtask

    // Result stall pattern: phases of always-ready, random, and mostly stalled.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(8, 80);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0: res_ch.ready = 1'b1;
            1: res_ch.ready = 1'($urandom_range(0, 1));
            default: res_ch.ready = ($urandom_range(0, 4) == 0);
        endcase
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        point_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_points.size() == 0)
            begin
                $error("Unexpected result x=%h y=%h z=%h", res_ch.out_x, res_ch.out_y,
                       res_ch.out_z);
                mismatches++;
            end
            else
            begin
                want = pending_points.pop_front();
                points_checked++;
                if (want.wz)
                    zero_w_seen++;
                if (res_ch.out_x !== want.ox)
                begin
                    $error("out_x: expected %h, actual %h", want.ox, res_ch.out_x);
                    mismatches++;
                end
                if (res_ch.out_y !== want.oy)
                begin
                    $error("out_y: expected %h, actual %h", want.oy, res_ch.out_y);
                    mismatches++;
                end
                if (res_ch.out_z !== want.oz)
                begin
                    $error("out_z: expected %h, actual %h", want.oz, res_ch.out_z);
                    mismatches++;
                end
                if (res_ch.w_zero_flag !== want.wz)
                begin
                    $error("w_zero_flag: expected %b, actual %b", want.wz,
                           res_ch.w_zero_flag);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        mismatches         = 0;
        loads_sent         = 0;
        points_sent        = 0;
        points_checked     = 0;
        zero_w_seen        = 0;
        burst_left         = 0;
        cycle_count        = 0;
        stall_mode         = 0;
        stall_left         = 0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_LOAD;
        req_ch.entry_index = '0;
        req_ch.coeff_value = '0;
        req_ch.point_x     = '0;
        req_ch.point_y     = '0;
        req_ch.point_z     = '0;
        res_ch.ready       = 1'b0;
        reset_shadow_matrix();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_identity_extremes();
        test_load_fields_ignored();
        test_perspective();
        test_zero_w();
        test_saturation();
        test_random_stream(1750);

        // Drop valid, drain outstanding results, then wait before the summary.
        req_ch.valid = 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d matrix loads and %0d transforms, %0d checked, %0d with zero w",
                 loads_sent, points_sent, points_checked, zero_w_seen);
        if (mismatches == 0 && pending_points.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- homogeneous_point_transform.f -----
rtl/core/hpt_pkg.sv
rtl/core/hpt_if.sv
rtl/core/hpt_matrix.sv
rtl/core/hpt_accum.sv
rtl/core/hpt_div.sv
rtl/core/homogeneous_point_transform.sv
tb/sv/homogeneous_point_transform_tb.sv
